[design/stc_pkg.sv]
// shared types, constants and character-class helpers for the source character tokenizer
// no dependencies; used by stc_scan, stc_outq and source_char_tokenizer
package stc_pkg;

    // input request: one source byte or an end marker
    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_text;
    } src_item_t;

    // one emitted token character
    typedef struct packed {
        logic [7:0] token_char;
        logic       token_first;
        logic       token_last;
        logic [2:0] token_kind;
        logic       batch_last;
    } tok_item_t;

    // up to two results produced by one input request, compacted into slot 0 first
    typedef struct packed {
        logic      v0;
        logic      v1;
        tok_item_t r0;
        tok_item_t r1;
    } push_t;

    typedef enum logic [6:0] {
        MODE_IDLE     = 7'b0000001,
        MODE_WORD     = 7'b0000010,
        MODE_NUMBER   = 7'b0000100,
        MODE_SLASH    = 7'b0001000,
        MODE_PLUSSTAR = 7'b0010000,
        MODE_LINE     = 7'b0100000,
        MODE_BLOCK    = 7'b1000000
    } mode_t;

    localparam logic [2:0] KIND_WORD  = 3'd0;
    localparam logic [2:0] KIND_INT   = 3'd1;
    localparam logic [2:0] KIND_FLOAT = 3'd2;
    localparam logic [2:0] KIND_SYM   = 3'd3;
    localparam logic [2:0] KIND_SYM2  = 3'd4;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A))
            || ((c >= 8'h61) && (c <= 8'h7A)) || (c == CH_UNDER);
    endfunction

endpackage

[design/stc_scan.sv]
// input register, scan mode machine and lookahead holding register of the tokenizer
// produces up to two results per request for stc_outq; depends on stc_pkg
module stc_scan (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  src_valid,
    output logic                  src_stall,
    input  stc_pkg::src_item_t    src_item,
    input  logic                  room,
    output stc_pkg::push_t        push
);

    logic                  inp_vld_reg;
    logic                  inp_vld_next;
    stc_pkg::src_item_t    inp_reg;
    logic                  step;

    stc_pkg::mode_t        mode_reg, mode_next;
    logic [7:0]            held_reg, held_next;
    logic                  held_vld_reg, held_vld_next;
    logic                  held_first_reg, held_first_next;
    logic                  dot_reg, dot_next;
    logic                  star_reg, star_next;

    logic [7:0]            c;
    logic                  st_emit, st_hold, st_dot;
    stc_pkg::mode_t        st_mode;
    stc_pkg::tok_item_t    st_r, fl_r, cont_r, s0, s1;
    logic                  s0_v, s1_v;
    logic                  use_flush, take_st;
    logic [2:0]            fl_kind;

    assign src_stall    = inp_vld_reg & ~room;
    assign step         = inp_vld_reg & room;
    assign inp_vld_next = src_stall ? inp_vld_reg : src_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inp_vld_reg <= 1'b0;
        end
        else
        begin
            inp_vld_reg <= inp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!src_stall && src_valid)
        begin
            inp_reg <= src_item;
        end
    end

    assign c = inp_reg.char_in;

    // classification of a byte that opens a new token
    always_comb
    begin
        st_emit = 1'b0;
        st_hold = 1'b0;
        st_dot  = 1'b0;
        st_mode = stc_pkg::MODE_IDLE;
        if (c == stc_pkg::CH_SPACE)
        begin
            st_mode = stc_pkg::MODE_IDLE;
        end
        else if (stc_pkg::is_digit(c) || (c == stc_pkg::CH_DOT))
        begin
            st_mode = stc_pkg::MODE_NUMBER;
            st_hold = 1'b1;
            st_dot  = (c == stc_pkg::CH_DOT);
        end
        else if (stc_pkg::is_word_char(c))
        begin
            st_mode = stc_pkg::MODE_WORD;
            st_hold = 1'b1;
        end
        else if (c == stc_pkg::CH_SLASH)
        begin
            st_mode = stc_pkg::MODE_SLASH;
            st_hold = 1'b1;
        end
        else if ((c == stc_pkg::CH_PLUS) || (c == stc_pkg::CH_STAR))
        begin
            st_mode = stc_pkg::MODE_PLUSSTAR;
            st_hold = 1'b1;
        end
        else
        begin
            st_emit = 1'b1;
        end
    end

    // kind of the held character when it closes its token
    always_comb
    begin
        fl_kind = stc_pkg::KIND_SYM;
        if (mode_reg == stc_pkg::MODE_WORD)
        begin
            fl_kind = stc_pkg::KIND_WORD;
        end
        else if (mode_reg == stc_pkg::MODE_NUMBER)
        begin
            if (held_first_reg && (held_reg == stc_pkg::CH_DOT))
            begin
                fl_kind = stc_pkg::KIND_SYM;
            end
            else
            begin
                fl_kind = dot_reg ? stc_pkg::KIND_FLOAT : stc_pkg::KIND_INT;
            end
        end
    end

    assign st_r   = '{token_char: c, token_first: 1'b1, token_last: 1'b1,
                      token_kind: stc_pkg::KIND_SYM, batch_last: 1'b0};
    assign fl_r   = '{token_char: held_reg, token_first: held_first_reg, token_last: 1'b1,
                      token_kind: fl_kind, batch_last: 1'b0};
    assign cont_r = '{token_char: held_reg, token_first: held_first_reg, token_last: 1'b0,
                      token_kind: stc_pkg::KIND_WORD, batch_last: 1'b0};

    always_comb
    begin
        mode_next       = mode_reg;
        held_next       = held_reg;
        held_vld_next   = held_vld_reg;
        held_first_next = held_first_reg;
        dot_next        = dot_reg;
        star_next       = star_reg;
        s0              = fl_r;
        s1              = st_r;
        s0_v            = 1'b0;
        s1_v            = 1'b0;
        use_flush       = 1'b0;
        take_st         = 1'b0;

        if (inp_reg.end_of_text)
        begin
            s0_v            = held_vld_reg;
            mode_next       = stc_pkg::MODE_IDLE;
            held_next       = 8'h00;
            held_vld_next   = 1'b0;
            held_first_next = 1'b0;
            dot_next        = 1'b0;
            star_next       = 1'b0;
        end
        else
        begin
            unique case (mode_reg)
                stc_pkg::MODE_WORD:
                begin
                    if (stc_pkg::is_word_char(c))
                    begin
                        s0              = cont_r;
                        s0_v            = 1'b1;
                        held_next       = c;
                        held_vld_next   = 1'b1;
                        held_first_next = 1'b0;
                    end
                    else
                    begin
                        use_flush = 1'b1;
                        take_st   = 1'b1;
                    end
                end
                stc_pkg::MODE_NUMBER:
                begin
                    if (stc_pkg::is_digit(c) || (c == stc_pkg::CH_DOT))
                    begin
                        s0              = cont_r;
                        s0_v            = 1'b1;
                        held_next       = c;
                        held_vld_next   = 1'b1;
                        held_first_next = 1'b0;
                        dot_next        = dot_reg | (c == stc_pkg::CH_DOT);
                    end
                    else
                    begin
                        use_flush = 1'b1;
                        take_st   = 1'b1;
                    end
                end
                stc_pkg::MODE_SLASH:
                begin
                    if (c == stc_pkg::CH_SLASH)
                    begin
                        held_next       = 8'h00;
                        held_vld_next   = 1'b0;
                        held_first_next = 1'b0;
                        dot_next        = 1'b0;
                        mode_next       = stc_pkg::MODE_LINE;
                    end
                    else if (c == stc_pkg::CH_STAR)
                    begin
                        held_next       = 8'h00;
                        held_vld_next   = 1'b0;
                        held_first_next = 1'b0;
                        dot_next        = 1'b0;
                        mode_next       = stc_pkg::MODE_BLOCK;
                        star_next       = 1'b1;
                    end
                    else
                    begin
                        use_flush = 1'b1;
                        take_st   = 1'b1;
                    end
                end
                stc_pkg::MODE_PLUSSTAR:
                begin
                    if (c == stc_pkg::CH_EQ)
                    begin
                        s0              = '{token_char: held_reg, token_first: 1'b1,
                                            token_last: 1'b0,
                                            token_kind: stc_pkg::KIND_WORD,
                                            batch_last: 1'b0};
                        s0_v            = 1'b1;
                        s1              = '{token_char: c, token_first: 1'b0,
                                            token_last: 1'b1,
                                            token_kind: stc_pkg::KIND_SYM2,
                                            batch_last: 1'b0};
                        s1_v            = 1'b1;
                        held_next       = 8'h00;
                        held_vld_next   = 1'b0;
                        held_first_next = 1'b0;
                        dot_next        = 1'b0;
                        mode_next       = stc_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        use_flush = 1'b1;
                        take_st   = 1'b1;
                    end
                end
                stc_pkg::MODE_LINE:
                begin
                    // the newline leaves the comment and is a symbol of its own
                    if (c == stc_pkg::CH_NL)
                    begin
                        take_st = 1'b1;
                    end
                end
                stc_pkg::MODE_BLOCK:
                begin
                    if (star_reg && (c == stc_pkg::CH_SLASH))
                    begin
                        star_next = 1'b0;
                        mode_next = stc_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        star_next = (c == stc_pkg::CH_STAR);
                    end
                end
                default:
                begin
                    take_st = 1'b1;
                end
            endcase

            if (take_st)
            begin
                if (use_flush && held_vld_reg)
                begin
                    s0   = fl_r;
                    s0_v = 1'b1;
                    s1   = st_r;
                    s1_v = st_emit;
                end
                else
                begin
                    s0   = st_r;
                    s0_v = st_emit;
                end
                mode_next       = st_mode;
                held_next       = st_hold ? c : 8'h00;
                held_vld_next   = st_hold;
                held_first_next = st_hold;
                dot_next        = st_dot;
            end
        end
    end

    always_comb
    begin
        push.v0            = step & s0_v;
        push.v1            = step & s1_v;
        push.r0            = s0;
        push.r0.batch_last = ~s1_v;
        push.r1            = s1;
        push.r1.batch_last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= stc_pkg::MODE_IDLE;
            held_reg       <= 8'h00;
            held_vld_reg   <= 1'b0;
            held_first_reg <= 1'b0;
            dot_reg        <= 1'b0;
            star_reg       <= 1'b0;
        end
        else if (step)
        begin
            mode_reg       <= mode_next;
            held_reg       <= held_next;
            held_vld_reg   <= held_vld_next;
            held_first_reg <= held_first_next;
            dot_reg        <= dot_next;
            star_reg       <= star_next;
        end
    end

endmodule

[design/stc_outq.sv]
// result queue of the tokenizer: takes up to two results a cycle, hands out one while tok_stall is low
// depends on stc_pkg for the result and push types and the queue depth
module stc_outq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  stc_pkg::push_t        push,
    output logic                  room,
    output logic                  tok_valid,
    input  logic                  tok_stall,
    output stc_pkg::tok_item_t    tok_item
);

    stc_pkg::tok_item_t               mem [stc_pkg::QUEUE_DEPTH];
    logic [stc_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [stc_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [stc_pkg::QCNT_W-1:0]       cnt_reg, cnt_next;
    logic [stc_pkg::QPTR_W-1:0]       wr_ptr_p1;
    logic [stc_pkg::QCNT_W-1:0]       n_push;
    logic                             pop;

    // a request may bring two results, so keep two slots free
    assign room      = (cnt_reg <= stc_pkg::QCNT_W'(stc_pkg::QUEUE_DEPTH - 2));
    assign tok_valid = (cnt_reg != '0);
    assign tok_item  = mem[rd_ptr_reg];
    assign pop       = tok_valid & ~tok_stall;
    assign wr_ptr_p1 = wr_ptr_reg + stc_pkg::QPTR_W'(1);

    assign n_push      = stc_pkg::QCNT_W'(push.v0) + stc_pkg::QCNT_W'(push.v1);
    assign wr_ptr_next = wr_ptr_reg + n_push[stc_pkg::QPTR_W-1:0];
    assign rd_ptr_next = rd_ptr_reg + stc_pkg::QPTR_W'(pop);
    assign cnt_next    = cnt_reg + n_push - stc_pkg::QCNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.v1)
        begin
            mem[wr_ptr_p1] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[design/source_char_tokenizer.sv]
// top level of the source character tokenizer: input stage and mode machine, result queue
// depends on stc_pkg, stc_scan and stc_outq
//
// Streaming tokenizer: one source byte per request in, one token character per result
// out, with first/last marks and the token kind on the last character. One byte is held
// as lookahead, so a held character appears one request after it arrives; an end-of-text
// request flushes it. A request is taken every cycle while the four-entry result queue
// has two free slots. Most requests give zero or one result; a held character followed
// by a symbol, or a two-character symbol, gives two, and the output drains one result
// per cycle while tok_stall is low, so a run of such requests is paced by the output.
// Each request is registered at the input and its results pass through the result queue.
module source_char_tokenizer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  src_valid,
    output logic                  src_stall,
    input  stc_pkg::src_item_t    src_item,
    output logic                  tok_valid,
    input  logic                  tok_stall,
    output stc_pkg::tok_item_t    tok_item
);

    stc_pkg::push_t push;
    logic           room;

    stc_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .room      (room),
        .push      (push)
    );

    stc_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_item  (tok_item)
    );

endmodule

[test/source_char_tokenizer_tb.sv]
`timescale 1ns / 1ps
// testbench for source_char_tokenizer: directed and random byte streams checked result by result
// against a behavioral tokenizer held in the bench; depends on stc_pkg and the tokenizer rtl
module source_char_tokenizer_tb;

    localparam int    ITEM_GOAL   = 1700;
    localparam int    STUCK_LIMIT = 5000;
    localparam int    TAIL_CYCLES = 16;
    localparam int    DRAIN_EVERY = 450;
    localparam int    HOLD_CYCLES = 300;
    localparam string SYM_SET     = "+*/=(;-\t,{";

    typedef struct packed {
        logic               drain;
        stc_pkg::src_item_t item;
    } feed_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               src_valid = 1'b0;
    logic               src_stall;
    stc_pkg::src_item_t src_item  = '0;
    logic               tok_valid;
    logic               tok_stall = 1'b0;
    stc_pkg::tok_item_t tok_item;

    feed_t              feed_q[$];
    stc_pkg::tok_item_t expected_chars[$];
    stc_pkg::tok_item_t batch[$];
    int        feed_count   = 0;
    int        fails        = 0;
    int        taken        = 0;
    bit        src_took     = 1'b0;
    int        gap_left     = 0;
    bit        tx_calm      = 1'b0;
    int        stall_left   = 0;
    int        hold_left    = 0;
    int        next_hold_at = 500;
    bit        rx_calm      = 1'b0;
    int        stuck        = 0;
    int        next_drain;

    // tokenizer state as the bench sees it
    stc_pkg::mode_t scan_st  = stc_pkg::MODE_IDLE;
    logic [7:0]     held_ch  = '0;
    logic           held_v   = 1'b0;
    logic           held_1st = 1'b0;
    logic           num_dot  = 1'b0;
    logic           star_hit = 1'b0;

    source_char_tokenizer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_item  (tok_item)
    );

    always #2 clk = ~clk;

    function automatic bit digit_ch(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic bit ident_ch(logic [7:0] c);
        return digit_ch(c) || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)
            || c == stc_pkg::CH_UNDER;
    endfunction

    function automatic void put_char(logic [7:0] c, logic first, logic last, logic [2:0] kind);
        stc_pkg::tok_item_t t;
        t.token_char  = c;
        t.token_first = first;
        t.token_last  = last;
        t.token_kind  = last ? kind : '0;
        t.batch_last  = 1'b0;
        batch.insert(batch.size(), t);
    endfunction

    function automatic void drop_held();
        held_v   = 1'b0;
        held_1st = 1'b0;
        held_ch  = '0;
        num_dot  = 1'b0;
    endfunction

    function automatic void keep_char(logic [7:0] c, logic first);
        held_ch  = c;
        held_v   = 1'b1;
        held_1st = first;
    endfunction

    // emit the lookahead character as the end of its token
    function automatic void flush_held();
        logic [2:0] kind;
        kind = stc_pkg::KIND_SYM;
        if (held_v)
        begin
            if (scan_st == stc_pkg::MODE_WORD)
                kind = stc_pkg::KIND_WORD;
            else if (scan_st == stc_pkg::MODE_NUMBER)
            begin
                if (held_1st && held_ch == stc_pkg::CH_DOT)
                    kind = stc_pkg::KIND_SYM;
                else
                    kind = num_dot ? stc_pkg::KIND_FLOAT : stc_pkg::KIND_INT;
            end
            put_char(held_ch, held_1st, 1'b1, kind);
            drop_held();
        end
    endfunction

    function automatic void begin_token(logic [7:0] c);
        scan_st = stc_pkg::MODE_IDLE;
        if (c != stc_pkg::CH_SPACE)
        begin
            if (digit_ch(c) || c == stc_pkg::CH_DOT)
            begin
                scan_st = stc_pkg::MODE_NUMBER;
                num_dot = (c == stc_pkg::CH_DOT);
                keep_char(c, 1'b1);
            end
            else if (ident_ch(c))
            begin
                scan_st = stc_pkg::MODE_WORD;
                keep_char(c, 1'b1);
            end
            else if (c == stc_pkg::CH_SLASH)
            begin
                scan_st = stc_pkg::MODE_SLASH;
                keep_char(c, 1'b1);
            end
            else if (c == stc_pkg::CH_PLUS || c == stc_pkg::CH_STAR)
            begin
                scan_st = stc_pkg::MODE_PLUSSTAR;
                keep_char(c, 1'b1);
            end
            else
                put_char(c, 1'b1, 1'b1, stc_pkg::KIND_SYM);
        end
    endfunction

    function automatic void predict_tokens(stc_pkg::src_item_t it);
        logic [7:0] c;
        c = it.char_in;
        batch.delete();
        if (it.end_of_text)
        begin
            flush_held();
            scan_st  = stc_pkg::MODE_IDLE;
            drop_held();
            star_hit = 1'b0;
        end
        else
        begin
            case (scan_st)
                stc_pkg::MODE_WORD:
                    if (ident_ch(c))
                    begin
                        put_char(held_ch, held_1st, 1'b0, '0);
                        keep_char(c, 1'b0);
                    end
                    else
                    begin
                        flush_held();
                        begin_token(c);
                    end
                stc_pkg::MODE_NUMBER:
                    if (digit_ch(c) || c == stc_pkg::CH_DOT)
                    begin
                        put_char(held_ch, held_1st, 1'b0, '0);
                        keep_char(c, 1'b0);
                        if (c == stc_pkg::CH_DOT)
                            num_dot = 1'b1;
                    end
                    else
                    begin
                        flush_held();
                        begin_token(c);
                    end
                stc_pkg::MODE_SLASH:
                    if (c == stc_pkg::CH_SLASH)
                    begin
                        drop_held();
                        scan_st = stc_pkg::MODE_LINE;
                    end
                    else if (c == stc_pkg::CH_STAR)
                    begin
                        drop_held();
                        scan_st  = stc_pkg::MODE_BLOCK;
                        star_hit = 1'b1;
                    end
                    else
                    begin
                        flush_held();
                        begin_token(c);
                    end
                stc_pkg::MODE_PLUSSTAR:
                    if (c == stc_pkg::CH_EQ)
                    begin
                        put_char(held_ch, 1'b1, 1'b0, '0);
                        put_char(c, 1'b0, 1'b1, stc_pkg::KIND_SYM2);
                        drop_held();
                        scan_st = stc_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        flush_held();
                        begin_token(c);
                    end
                stc_pkg::MODE_LINE:
                    // the newline leaves the comment and is a symbol of its own
                    if (c == stc_pkg::CH_NL)
                        begin_token(c);
                stc_pkg::MODE_BLOCK:
                    if (star_hit && c == stc_pkg::CH_SLASH)
                    begin
                        star_hit = 1'b0;
                        scan_st  = stc_pkg::MODE_IDLE;
                    end
                    else
                        star_hit = (c == stc_pkg::CH_STAR);
                default:
                begin
                    drop_held();
                    begin_token(c);
                end
            endcase
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].batch_last = 1'b1;
        foreach (batch[i])
            expected_chars.insert(expected_chars.size(), batch[i]);
    endfunction

    function automatic void add_byte(logic [7:0] c);
        feed_t f;
        f.drain            = 1'b0;
        f.item.char_in     = c;
        f.item.end_of_text = 1'b0;
        feed_q.insert(feed_q.size(), f);
        feed_count++;
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    function automatic void add_end();
        feed_t f;
        f.drain            = 1'b0;
        f.item.char_in     = 8'($urandom_range(0, 255));
        f.item.end_of_text = 1'b1;
        feed_q.insert(feed_q.size(), f);
        feed_count++;
    endfunction

    // sender waits here until every expected result is back
    function automatic void add_drain();
        feed_t f;
        f.drain = 1'b1;
        f.item  = '0;
        feed_q.insert(feed_q.size(), f);
    endfunction

    function automatic logic [7:0] pick_ident(bit lead);
        int r;
        r = $urandom_range(0, lead ? 52 : 62);
        if (r < 26)
            return 8'(8'h61 + r);
        else if (r < 52)
            return 8'(8'h41 + r - 26);
        else if (r == 52)
            return stc_pkg::CH_UNDER;
        else
            return 8'(8'h30 + r - 53);
    endfunction

    function automatic logic [7:0] pick_body();
        case ($urandom_range(0, 4))
            0:       return stc_pkg::CH_STAR;
            1:       return stc_pkg::CH_SLASH;
            2:       return stc_pkg::CH_SPACE;
            3:       return pick_ident(1'b0);
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one well-formed lexeme, comment, bit of noise or end request
    function automatic void add_random_run();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 28)
        begin
            add_byte(pick_ident(1'b1));
            n = $urandom_range(0, 6);
            repeat (n) add_byte(pick_ident(1'b0));
        end
        else if (r < 46)
        begin
            n = $urandom_range(1, 5);
            repeat (n)
                add_byte(($urandom_range(0, 4) == 0) ? stc_pkg::CH_DOT
                                                     : 8'(8'h30 + $urandom_range(0, 9)));
        end
        else if (r < 58)
        begin
            add_byte(stc_pkg::CH_SPACE);
            if ($urandom_range(0, 3) == 0)
                add_byte(stc_pkg::CH_SPACE);
        end
        else if (r < 72)
        begin
            case ($urandom_range(0, 5))
                0:       add_text("+=");
                1:       add_text("*=");
                2:       add_byte(stc_pkg::CH_NL);
                default: add_byte(SYM_SET[$urandom_range(0, SYM_SET.len() - 1)]);
            endcase
        end
        else if (r < 80)
        begin
            add_text("//");
            n = $urandom_range(0, 5);
            repeat (n) add_byte(pick_body());
            add_byte(stc_pkg::CH_NL);
        end
        else if (r < 88)
        begin
            add_text("/*");
            if ($urandom_range(0, 4) == 0)
                add_byte(stc_pkg::CH_SLASH);
            else
            begin
                n = $urandom_range(0, 5);
                repeat (n) add_byte(pick_body());
                add_text("*/");
            end
        end
        else if (r < 97)
            add_byte(8'($urandom_range(0, 255)));
        else
            add_end();
    endfunction

    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    // request driver
    always @(negedge clk)
    begin : drive_src
        feed_t nxt;
        if (rst_n && (!src_valid || src_took))
        begin
            if (gap_left > 0)
            begin
                src_valid <= 1'b0;
                gap_left--;
            end
            else if (feed_q.size() == 0)
                src_valid <= 1'b0;
            else if (feed_q[0].drain)
            begin
                src_valid <= 1'b0;
                if (expected_chars.size() == 0)
                    feed_q.delete(0);
            end
            else
            begin
                nxt = feed_q.pop_front();
                src_item  <= nxt.item;
                src_valid <= 1'b1;
                if ($urandom_range(0, 49) == 0)
                    tx_calm = !tx_calm;
                gap_left = pick_gap(tx_calm);
            end
        end
    end

    // result receiver stalls
    always @(negedge clk)
    begin : drive_tok_stall
        int r;
        if (hold_left > 0)
        begin
            tok_stall <= 1'b1;
            hold_left--;
        end
        else if (taken >= next_hold_at)
        begin
            // long hold-off so the result queue fills and backs up the input
            tok_stall <= 1'b1;
            hold_left = HOLD_CYCLES - 1;
            next_hold_at += 700;
        end
        else if (stall_left > 0)
        begin
            tok_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                rx_calm = !rx_calm;
            r = $urandom_range(0, 99);
            if (rx_calm)
                tok_stall <= 1'b0;
            else if (r < 4)
            begin
                tok_stall <= 1'b1;
                stall_left = $urandom_range(4, 30);
            end
            else
                tok_stall <= (r < 30);
        end
    end

    // monitor: predict on accepted requests, check accepted results, watchdog
    always @(posedge clk)
    begin : watch_ports
        stc_pkg::tok_item_t want;
        src_took = 1'b0;
        if (rst_n)
        begin
            if (src_valid && !src_stall)
            begin
                predict_tokens(src_item);
                src_took = 1'b1;
                taken++;
            end
            if (tok_valid && !tok_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected token character %0h", tok_item.token_char);
                    fails++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    check_field("token_char", want.token_char, tok_item.token_char);
                    check_field("token_first", want.token_first, tok_item.token_first);
                    check_field("token_last", want.token_last, tok_item.token_last);
                    check_field("token_kind", want.token_kind, tok_item.token_kind);
                    check_field("batch_last", want.batch_last, tok_item.batch_last);
                end
            end
            if ((src_valid && !src_stall) || (tok_valid && !tok_stall))
                stuck = 0;
            else
                stuck++;
            if (stuck >= STUCK_LIMIT)
            begin
                $display("source_char_tokenizer verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        // word, two-char symbol, lone dot, float, star-equal
        add_text("_9+=.");
        add_text("\t");
        add_text("1.*=");
        // block comment closed on the opener's star, then an empty line comment
        add_text("/*/");
        add_text("//\n");
        // slash that is not a comment, then control and high bytes
        add_text("/a");
        add_byte(8'h00);
        add_byte(8'hFF);
        add_end();
        // end flushes a pending plus; unterminated block comment swallowed
        add_text("+");
        add_end();
        add_text("/*q");
        add_end();
        add_drain();

        next_drain = feed_count + DRAIN_EVERY;
        while (feed_count < ITEM_GOAL)
        begin
            add_random_run();
            if (feed_count >= next_drain)
            begin
                add_drain();
                next_drain += DRAIN_EVERY;
            end
        end
        add_end();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (feed_q.size() != 0 || src_valid || expected_chars.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("source_char_tokenizer verification clean");
        else
            $display("source_char_tokenizer verification failed");
        $finish;
    end

endmodule

[files.f]
design/stc_pkg.sv
design/stc_scan.sv
design/stc_outq.sv
design/source_char_tokenizer.sv
test/source_char_tokenizer_tb.sv
